// ===== rtl/nsel_pkg.sv =====
// ----------------------------------------------------------------------------
// nsel_pkg
// Shared sizes, codes and the request record of the no-wait record lock.
// ----------------------------------------------------------------------------
package nsel_pkg;

  localparam int MAX_OWNERS  = 16;
  localparam int CLIENT_BITS = 16;

  // Fixed field widths of the request and response channels
  localparam int MODE_W   = 2;
  localparam int ID_IN_W  = 16;
  localparam int STATUS_W = 2;
  localparam int HELD_W   = 2;
  localparam int COUNT_W  = 5;

  // Owner count must hold MAX_OWNERS itself
  localparam int SLOT_CNT_W = $clog2(MAX_OWNERS + 1);

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request mode codes
  localparam logic [MODE_W-1:0] MODE_ACQ_SH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACQ_EX  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

  // Response status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REFUSED  = 2'd3;

  // Held lock mode codes
  localparam logic [HELD_W-1:0] HM_NONE   = 2'd0;
  localparam logic [HELD_W-1:0] HM_SHARED = 2'd1;
  localparam logic [HELD_W-1:0] HM_EXCL   = 2'd2;

  typedef enum logic [1:0] {
    OP_ACQUIRE,
    OP_RELEASE,
    OP_IGNORE
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [HELD_W-1:0]      want;
    logic [CLIENT_BITS-1:0] id;
  } req_t;

endpackage

// ===== rtl/nsel_front.sv =====
// ----------------------------------------------------------------------------
// nsel_front
// Takes request beats, classifies the mode and casts the client id to CLIENT_BITS.
// ----------------------------------------------------------------------------
module nsel_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [nsel_pkg::MODE_W-1:0]    mode,
  input  logic [nsel_pkg::ID_IN_W-1:0]   requester,
  output logic                           push_valid,
  output nsel_pkg::req_t                 push_data,
  input  logic                           push_ready
);
  import nsel_pkg::*;

  logic hold_valid;
  req_t hold_req;
  req_t req_next;

  always_comb begin
    req_next.id   = CLIENT_BITS'(requester);
    req_next.want = HM_SHARED;
    case (mode)
      MODE_ACQ_SH: begin
        req_next.op   = OP_ACQUIRE;
        req_next.want = HM_SHARED;
      end
      MODE_ACQ_EX: begin
        req_next.op   = OP_ACQUIRE;
        req_next.want = HM_EXCL;
      end
      MODE_RELEASE: begin
        req_next.op = OP_RELEASE;
      end
      default: begin
        req_next.op = OP_IGNORE;
      end
    endcase
  end

  assign req_ready  = !hold_valid || push_ready;
  assign push_valid = hold_valid;
  assign push_data  = hold_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold_req <= req_next;
    end
  end

endmodule

// ===== rtl/nsel_queue.sv =====
// ----------------------------------------------------------------------------
// nsel_queue
// Short request FIFO that decouples the classifier from the lock table.
// ----------------------------------------------------------------------------
module nsel_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  nsel_pkg::req_t push_data,
  output logic           push_ready,
  output logic           pop_valid,
  output nsel_pkg::req_t pop_data,
  input  logic           pop
);
  import nsel_pkg::*;

  req_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/nsel_back.sv =====
// ----------------------------------------------------------------------------
// nsel_back
// Owner table: matches a request against all slots, then applies it.
// ----------------------------------------------------------------------------
module nsel_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  nsel_pkg::req_t                  head,
  output logic                            pop,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [nsel_pkg::STATUS_W-1:0]   status,
  output logic [nsel_pkg::HELD_W-1:0]     held_mode,
  output logic [nsel_pkg::COUNT_W-1:0]    owner_count
);
  import nsel_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t                  state;
  logic [MAX_OWNERS-1:0]   owner_valid;
  logic [CLIENT_BITS-1:0]  owner_ids [MAX_OWNERS];
  logic [SLOT_CNT_W-1:0]   owners_held;
  logic [HELD_W-1:0]       lock_mode_held;

  // Lookup results for the item in flight
  op_t                     cur_op;
  logic [HELD_W-1:0]       cur_want;
  logic [CLIENT_BITS-1:0]  cur_id;
  logic                    cur_conflict;
  logic [MAX_OWNERS-1:0]   grant_oh;
  logic [MAX_OWNERS-1:0]   rel_oh;

  logic [MAX_OWNERS-1:0]   free_vec;
  logic [MAX_OWNERS-1:0]   match_vec;
  logic [MAX_OWNERS-1:0]   free_oh_next;
  logic [MAX_OWNERS-1:0]   rel_oh_next;
  logic                    conflict_next;

  logic [STATUS_W-1:0]     status_next;
  logic [HELD_W-1:0]       held_next;
  logic [SLOT_CNT_W-1:0]   cnt_next;
  logic [MAX_OWNERS-1:0]   valid_next;
  logic [31:0]             cnt_wide;
  logic                    commit;

  // Parallel slot match and lowest-free pick
  always_comb begin
    free_vec = ~owner_valid;
    for (int i = 0; i < MAX_OWNERS; i++) begin
      match_vec[i] = owner_valid[i] && (owner_ids[i] == head.id);
    end
    free_oh_next  = free_vec & (~free_vec + 1'b1);
    rel_oh_next   = match_vec & (~match_vec + 1'b1);
    conflict_next = (lock_mode_held != HM_NONE) &&
                    ((lock_mode_held == HM_EXCL) || (head.want == HM_EXCL));
  end

  always_comb begin
    status_next = ST_REFUSED;
    held_next   = lock_mode_held;
    cnt_next    = owners_held;
    valid_next  = owner_valid;
    case (cur_op)
      OP_ACQUIRE: begin
        if (cur_conflict) begin
          status_next = ST_CONFLICT;
        end else if (|grant_oh) begin
          valid_next  = owner_valid | grant_oh;
          cnt_next    = owners_held + SLOT_CNT_W'(1);
          held_next   = cur_want;
          status_next = ST_GRANTED;
        end
      end
      OP_RELEASE: begin
        if (|rel_oh) begin
          valid_next = owner_valid & ~rel_oh;
          if (owners_held != '0) begin
            cnt_next = owners_held - SLOT_CNT_W'(1);
          end
          if (cnt_next == '0) begin
            held_next = HM_NONE;
          end
          status_next = ST_RELEASED;
        end
      end
      default: begin
      end
    endcase
    cnt_wide = 32'(cnt_next);
  end

  assign pop    = (state == S_IDLE) && head_valid;
  assign commit = (state == S_APPLY) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      owner_valid    <= '0;
      owners_held    <= '0;
      lock_mode_held <= HM_NONE;
      rsp_valid      <= 1'b0;
    end else begin
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            cur_op       <= head.op;
            cur_want     <= head.want;
            cur_id       <= head.id;
            cur_conflict <= conflict_next;
            grant_oh     <= free_oh_next;
            rel_oh       <= rel_oh_next;
            state        <= S_APPLY;
          end
        end
        S_APPLY: begin
          // hold until the output register is free
          if (commit) begin
            owner_valid    <= valid_next;
            owners_held    <= cnt_next;
            lock_mode_held <= held_next;
            status         <= status_next;
            held_mode      <= held_next;
            owner_count    <= cnt_wide[COUNT_W-1:0];
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_OWNERS; i++) begin
      if (commit && (cur_op == OP_ACQUIRE) && !cur_conflict && grant_oh[i]) begin
        owner_ids[i] <= cur_id;
      end
    end
  end

endmodule

// ===== rtl/nowait_shared_exclusive_lock.sv =====
// ----------------------------------------------------------------------------
// nowait_shared_exclusive_lock
// No-wait shared/exclusive record lock with a small owner table.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  request | req_valid, req_ready | mode, requester
//  result  | rsp_valid, rsp_ready | status, held_mode, owner_count
//
//  The table takes a new request only after applying the last, by its
//  lookup-then-apply sequence. The front register and a 2-entry queue keep
//  taking requests while a result waits; the table holds in its apply step
//  until the result is free. Reset clears all valid bits, the count and
//  the held mode.
// ----------------------------------------------------------------------------
module nowait_shared_exclusive_lock (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic [nsel_pkg::MODE_W-1:0]     mode,
  input  logic [nsel_pkg::ID_IN_W-1:0]    requester,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [nsel_pkg::STATUS_W-1:0]   status,
  output logic [nsel_pkg::HELD_W-1:0]     held_mode,
  output logic [nsel_pkg::COUNT_W-1:0]    owner_count
);
  import nsel_pkg::*;

  logic push_valid;
  req_t push_data;
  logic push_ready;
  logic head_valid;
  req_t head;
  logic pop;

  nsel_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .mode       (mode),
    .requester  (requester),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  nsel_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (head_valid),
    .pop_data   (head),
    .pop        (pop)
  );

  nsel_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .held_mode   (held_mode),
    .owner_count (owner_count)
  );

  a_conflict_needs_lock: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_CONFLICT) |-> (held_mode != HM_NONE))
    else $error("conflict reported with no lock held");

  a_grant_sets_mode: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_GRANTED) |-> (held_mode != HM_NONE))
    else $error("grant left lock mode at none");

  a_excl_single_owner: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_GRANTED && held_mode == HM_EXCL)
      |-> (owner_count == COUNT_W'(1)))
    else $error("exclusive grant with more than one owner");

  a_pop_one_per_two: assert property (@(posedge clk) disable iff (rst)
    pop |=> !pop)
    else $error("table took requests in back-to-back cycles");

endmodule

// ===== tb/sv/tb_nowait_shared_exclusive_lock.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nowait_shared_exclusive_lock
// Self-checking bench for the no-wait record lock. A scoreboard keeps its own
// owner table, predicts status, held mode and owner count for each request
// beat, and compares each result beat in order. The stimulus starts with
// directed corner cases. Lock sessions with random ids, full-table fills and
// noise follow, with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb_nowait_shared_exclusive_lock;
  import nsel_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int NUM_ITEMS   = 450;
  localparam int QUIET_FROM  = 390;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 80;
  localparam int PAUSE_AT    = 300;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HELD_W-1:0]   held;
    logic [COUNT_W-1:0]  count;
  } lock_result_t;

  class lock_scoreboard;
    bit                     owner_live [MAX_OWNERS];
    logic [CLIENT_BITS-1:0] owner_id [MAX_OWNERS];
    int unsigned            owners;
    logic [HELD_W-1:0]      held;
    lock_result_t           expected_results [$];
    int unsigned            errors;

    function new();
      foreach (owner_live[i]) owner_live[i] = 1'b0;
      owners = 0;
      held   = HM_NONE;
      errors = 0;
    endfunction

    // Predict the result of one accepted request and update the owner table
    function void note_request(logic [MODE_W-1:0] m, logic [ID_IN_W-1:0] id);
      lock_result_t           r;
      logic [HELD_W-1:0]      want;
      logic [CLIENT_BITS-1:0] key;
      int                     slot;
      key      = id[CLIENT_BITS-1:0];
      slot     = -1;
      r.status = ST_REFUSED;
      if (m == MODE_ACQ_SH || m == MODE_ACQ_EX) begin
        want = (m == MODE_ACQ_SH) ? HM_SHARED : HM_EXCL;
        // conflict is decided before looking for a free slot
        if (held != HM_NONE && (held == HM_EXCL || want == HM_EXCL)) begin
          r.status = ST_CONFLICT;
        end else begin
          for (int i = 0; i < MAX_OWNERS; i++)
            if (slot < 0 && !owner_live[i]) slot = i;
          if (slot >= 0) begin
            owner_id[slot]   = key;
            owner_live[slot] = 1'b1;
            owners++;
            held     = want;
            r.status = ST_GRANTED;
          end
        end
      end else if (m == MODE_RELEASE) begin
        for (int i = 0; i < MAX_OWNERS; i++)
          if (slot < 0 && owner_live[i] && owner_id[i] == key) slot = i;
        if (slot >= 0) begin
          owner_live[slot] = 1'b0;
          if (owners > 0) owners--;
          if (owners == 0) held = HM_NONE;
          r.status = ST_RELEASED;
        end
      end
      r.held  = held;
      r.count = owners[COUNT_W-1:0];
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [HELD_W-1:0] hm,
                               logic [COUNT_W-1:0] cnt);
      lock_result_t e;
      if (expected_results.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (hm !== e.held) begin
        $error("held_mode: expected %0d, actual %0d", e.held, hm);
        errors++;
      end
      if (cnt !== e.count) begin
        $error("owner_count: expected %0d, actual %0d", e.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  logic [MODE_W-1:0]     mode = MODE_ACQ_SH;
  logic [ID_IN_W-1:0]    requester = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [HELD_W-1:0]     held_mode;
  logic [COUNT_W-1:0]    owner_count;

  lock_scoreboard sb;
  int  sent = 0;
  bit  quiet = 1'b0;
  bit  rsp_hold_req = 1'b0;
  logic [ID_IN_W-1:0] id_pool [6];

  nowait_shared_exclusive_lock DUT (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .mode        (mode),
    .requester   (requester),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .held_mode   (held_mode),
    .owner_count (owner_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Present one request beat and hold it until accepted
  task automatic send_request(logic [MODE_W-1:0] m, logic [ID_IN_W-1:0] id);
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 18);
      @(negedge clk);
      req_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid = 1'b1;
    mode      = m;
    requester = id;
    do @(posedge clk); while (!req_ready);
    sb.note_request(m, id);
    sent++;
    quiet = (sent >= QUIET_FROM);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_valid = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ID_IN_W-1:0] rand_id();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return ID_IN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void fresh_pool();
    foreach (id_pool[i]) id_pool[i] = rand_id();
  endfunction

  // Release every current owner in random order, with a stray release now and then
  task automatic release_all();
    logic [ID_IN_W-1:0] live_ids [$];
    int idx;
    foreach (sb.owner_live[i])
      if (sb.owner_live[i]) live_ids.push_back(sb.owner_id[i]);
    while (live_ids.size() != 0) begin
      if ($urandom_range(0, 9) == 0) send_request(MODE_RELEASE, rand_id());
      idx = $urandom_range(0, live_ids.size() - 1);
      send_request(MODE_RELEASE, live_ids[idx]);
      live_ids.delete(idx);
    end
  endtask

  task automatic run_shared_group();
    int n;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, MAX_OWNERS) : $urandom_range(1, 6);
    fresh_pool();
    repeat (n) begin
      if ($urandom_range(0, 5) == 0)
        send_request(MODE_ACQ_EX, id_pool[$urandom_range(0, 5)]);
      send_request(MODE_ACQ_SH, id_pool[$urandom_range(0, 5)]);
    end
    release_all();
  endtask

  task automatic run_exclusive();
    logic [ID_IN_W-1:0] owner;
    owner = rand_id();
    send_request(MODE_ACQ_EX, owner);
    repeat ($urandom_range(0, 3))
      send_request($urandom_range(0, 1) ? MODE_ACQ_EX : MODE_ACQ_SH, rand_id());
    if ($urandom_range(0, 1) == 0) send_request(MODE_RELEASE, owner ^ ID_IN_W'(1));
    send_request(MODE_RELEASE, owner);
    if ($urandom_range(0, 2) == 0) send_request(MODE_RELEASE, owner);
  endtask

  task automatic run_fill();
    fresh_pool();
    repeat (MAX_OWNERS) send_request(MODE_ACQ_SH, id_pool[$urandom_range(0, 5)]);
    repeat ($urandom_range(1, 2)) send_request(MODE_ACQ_SH, rand_id());
    send_request(MODE_ACQ_EX, rand_id());
    release_all();
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 6))
      send_request(MODE_W'($urandom_range(0, 3)), rand_id());
  endtask

  // Receiver: random ready bursts, one long hold-off on request
  initial begin
    wait (!rst);
    @(negedge clk);
    forever begin
      if (rsp_hold_req) begin
        rsp_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rsp_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_ready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        rsp_ready = 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready)
      sb.check_result(status, held_mode, owner_count);
  end

  initial begin
    bit did_hold;
    bit did_pause;
    did_hold  = 1'b0;
    did_pause = 1'b0;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed corners
    send_request(MODE_RELEASE, 16'h1234);   // release with nothing held
    send_request(MODE_UNUSED, 16'hFFFF);    // unused mode on an idle lock
    send_request(MODE_ACQ_EX, 16'hFFFF);
    send_request(MODE_ACQ_SH, 16'h0000);    // shared against exclusive
    send_request(MODE_ACQ_EX, 16'h0001);    // exclusive against exclusive
    send_request(MODE_UNUSED, 16'h0000);    // unused mode while held
    send_request(MODE_RELEASE, 16'hFFFF);
    send_request(MODE_ACQ_SH, 16'h0000);
    send_request(MODE_ACQ_SH, 16'h0000);    // same client twice
    send_request(MODE_ACQ_SH, 16'hA5A5);
    send_request(MODE_ACQ_EX, 16'h5A5A);    // exclusive against shared
    send_request(MODE_RELEASE, 16'hFFFE);   // not an owner
    send_request(MODE_RELEASE, 16'h0000);
    send_request(MODE_RELEASE, 16'hA5A5);
    send_request(MODE_RELEASE, 16'h0000);   // count back to zero
    send_request(MODE_RELEASE, 16'h0000);   // already gone

    // full table first, then mixed sessions
    run_fill();
    while (sent < NUM_ITEMS) begin
      if (!did_hold && sent >= HOLD_AT) begin
        rsp_hold_req = 1'b1;
        did_hold     = 1'b1;
      end
      if (!did_pause && sent >= PAUSE_AT) begin
        wait_drained();
        did_pause = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: run_shared_group();
        5, 6:          run_exclusive();
        7:             run_fill();
        default:       run_noise();
      endcase
    end
    release_all();

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/nsel_pkg.sv
rtl/nsel_front.sv
rtl/nsel_queue.sv
rtl/nsel_back.sv
rtl/nowait_shared_exclusive_lock.sv
tb/sv/tb_nowait_shared_exclusive_lock.sv
